// ----- hw/rtl/prr_pkg.sv -----
// Shared types and constants of the polyphase rational resampler.
// No dependencies; every other file in this folder but prr_ram uses it by scoped name.
package prr_pkg;

  // Field and register widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PHASE_W    = 6;
  localparam int unsigned TAP_IDX_W  = 6;

  // Storage sizes
  localparam int unsigned MAX_PHASES = 64;
  localparam int unsigned MAX_TAPS   = 64;
  localparam int unsigned TAP_ADDR_W = PHASE_W + TAP_IDX_W;
  localparam int unsigned HIST_W     = 2 * SAMPLE_W;

  // Datapath
  localparam int unsigned PROD_W     = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W      = PROD_W + 8;
  localparam int unsigned OUT_LIMIT  = 64;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd2;

  // Request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_EMIT
  } prr_state_e;

  // Divider control and result
  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } prr_div_req_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] quot;
    logic [CFG_W-1:0] rem;
  } prr_div_rsp_t;

  // MAC control
  typedef struct packed {
    logic clr;
    logic vld;
  } prr_mac_ctl_t;

endpackage

// ----- hw/rtl/prr_if.sv -----
// Valid/ready channel interfaces of the resampler: request in, result out.
// Depends on prr_pkg for field widths.
interface prr_req_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [prr_pkg::SAMPLE_W-1:0] sample_i;
  logic signed [prr_pkg::SAMPLE_W-1:0] sample_q;
  logic [prr_pkg::PHASE_W-1:0]         coef_phase;
  logic [prr_pkg::TAP_IDX_W-1:0]       coef_index;
  logic signed [prr_pkg::COEF_W-1:0]   coef_value;

  modport source (
    output valid, op, sample_i, sample_q, coef_phase, coef_index, coef_value,
    input  ready
  );
  modport sink (
    input  valid, op, sample_i, sample_q, coef_phase, coef_index, coef_value,
    output ready
  );
endinterface

interface prr_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [prr_pkg::SAMPLE_W-1:0] out_i;
  logic signed [prr_pkg::SAMPLE_W-1:0] out_q;
  logic                                last;

  modport source (
    output valid, out_i, out_q, last,
    input  ready
  );
  modport sink (
    input  valid, out_i, out_q, last,
    output ready
  );
endinterface

// ----- hw/rtl/prr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/prr_div.sv -----
// Restoring divider, one quotient bit per cycle, for the phase/advance update.
// Depends on prr_pkg for widths and request/response structs.
module prr_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prr_pkg::prr_div_req_t req_i,
  output prr_pkg::prr_div_rsp_t rsp_o
);

  localparam int unsigned W    = prr_pkg::CFG_W;
  localparam int unsigned CNTW = $clog2(W + 1);

  logic [W:0]      rem_q;
  logic [W-1:0]    quo_q;
  logic [W-1:0]    den_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [W:0]      shifted;
  logic [W:0]      diff;
  logic            fits;

  // One shift-and-subtract step
  assign shifted = {rem_q[W-1:0], quo_q[W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNTW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff : shifted;
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q[W-1:0];

endmodule

// ----- hw/rtl/prr_mac.sv -----
// Shared complex-by-real multiply-accumulate with round and saturate.
// Depends on prr_pkg for widths and the control struct.
module prr_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  prr_pkg::prr_mac_ctl_t               ctl_i,
  input  logic signed [prr_pkg::SAMPLE_W-1:0] smp_i_i,
  input  logic signed [prr_pkg::SAMPLE_W-1:0] smp_q_i,
  input  logic signed [prr_pkg::COEF_W-1:0]   coef_i,
  output logic signed [prr_pkg::SAMPLE_W-1:0] res_i_o,
  output logic signed [prr_pkg::SAMPLE_W-1:0] res_q_o
);

  localparam int unsigned PW   = prr_pkg::PROD_W;
  localparam int unsigned AW   = prr_pkg::ACC_W;
  localparam int unsigned SW   = prr_pkg::SAMPLE_W;
  localparam int unsigned SH   = prr_pkg::COEF_W - 1;
  localparam int unsigned RW   = AW - SH;

  logic              prod_v_q;
  logic signed [PW-1:0] prod_i_q;
  logic signed [PW-1:0] prod_q_q;
  logic signed [AW-1:0] acc_i_q;
  logic signed [AW-1:0] acc_q_q;

  // Add half an LSB, shift down, clip to the output width
  function automatic logic signed [SW-1:0] round_sat(input logic signed [AW-1:0] acc);
    logic [AW-1:0] r;
    logic [RW-1:0] s;
    logic          ovf;
    r   = acc + (AW'(1) << (SH - 1));
    s   = r[AW-1:SH];
    ovf = (s[RW-1:SW-1] != {(RW - SW + 1){s[SW-1]}});
    if (!ovf) begin
      round_sat = s[SW-1:0];
    end else if (s[RW-1]) begin
      round_sat = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      round_sat = {1'b0, {(SW - 1){1'b1}}};
    end
  endfunction

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      prod_i_q <= smp_i_i * coef_i;
      prod_q_q <= smp_q_i * coef_i;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (prod_v_q) begin
      acc_i_q <= acc_i_q + {{(AW - PW){prod_i_q[PW-1]}}, prod_i_q};
      acc_q_q <= acc_q_q + {{(AW - PW){prod_q_q[PW-1]}}, prod_q_q};
    end
  end

  assign res_i_o = round_sat(acc_i_q);
  assign res_q_o = round_sat(acc_q_q);

endmodule

// ----- hw/rtl/polyphase_rational_resampler_top.sv -----
// Rational L/M polyphase resampler for complex 16-bit samples. Coefficient
// and sample requests are taken only while the block is idle. After a sample
// request the block is busy until all outputs it causes (at most 64) have been
// handed to the output register; each output takes one pass of the single
// shared MAC over the branch taps, then the divider that advances phase and
// counter, then the load of the output register, which is held while that
// register still waits on the receiver. A sample that causes no output leaves
// the block idle. The history line comes out of reset as all zeros through
// per-entry valid bits, so no clearing pass is needed. Depends on prr_pkg,
// prr_if, prr_ram, prr_div and prr_mac.
module polyphase_rational_resampler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [prr_pkg::CFG_W-1:0]      cfg_wdata_i,
  prr_req_if.sink                        in_ch,
  prr_res_if.source                      out_ch
);

  localparam int unsigned CW  = prr_pkg::CFG_W;
  localparam int unsigned PHW = prr_pkg::PHASE_W;
  localparam int unsigned TIW = prr_pkg::TAP_IDX_W;
  localparam int unsigned SW  = prr_pkg::SAMPLE_W;
  localparam int unsigned NT  = prr_pkg::MAX_TAPS;

  // Configuration registers
  logic [CW-1:0] interp_q, decim_q, taps_q;
  logic [CW-1:0] interp_cl, decim_cl, taps_cl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= CW'(1);
      decim_q  <= CW'(1);
      taps_q   <= CW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prr_pkg::CFG_INTERP: interp_q <= cfg_wdata_i;
        prr_pkg::CFG_DECIM:  decim_q  <= cfg_wdata_i;
        prr_pkg::CFG_TAPS:   taps_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp to the supported ranges, zero acts as one
  always_comb begin
    interp_cl = (interp_q == '0) ? CW'(1) :
                (interp_q > CW'(prr_pkg::MAX_PHASES)) ? CW'(prr_pkg::MAX_PHASES) : interp_q;
    decim_cl  = (decim_q == '0) ? CW'(1) :
                (decim_q > CW'(prr_pkg::MAX_PHASES)) ? CW'(prr_pkg::MAX_PHASES) : decim_q;
    taps_cl   = (taps_q == '0) ? CW'(1) :
                (taps_q > CW'(NT)) ? CW'(NT) : taps_q;
  end

  // Sequencer state
  prr_pkg::prr_state_e state_q, state_d;
  logic [CW-1:0]       k_q, k_d;
  logic [TIW-1:0]      cnt_q, cnt_d;
  logic [PHW-1:0]      phase_q, phase_d;
  logic [CW-1:0]       adv_q, adv_d;
  logic [CW-1:0]       adv_dec;
  logic [TIW-1:0]      wp_q, wp_d;
  logic [NT-1:0]       hvalid_q, hvalid_d;
  logic                rd_v_q;
  logic                hv_q;

  logic                in_ready;
  logic                tap_we;
  logic                hist_we;
  logic                issue;
  logic                out_load;
  logic                res_last;
  logic [CW-1:0]       mac_end;
  logic [TIW-1:0]      hist_waddr;
  logic [TIW-1:0]      hist_base;
  logic [TIW-1:0]      hist_raddr;

  prr_pkg::prr_div_req_t div_req;
  prr_pkg::prr_div_rsp_t div_rsp;
  prr_pkg::prr_mac_ctl_t mac_ctl;

  // History addressing: wp points at the newest sample
  assign hist_waddr = wp_q + TIW'(1);
  assign hist_base  = wp_q + TIW'(1) - taps_cl[TIW-1:0];
  assign hist_raddr = hist_base + k_q[TIW-1:0];
  assign mac_end    = taps_cl + CW'(2);
  assign issue      = (state_q == prr_pkg::ST_MAC) && (k_q < taps_cl);
  assign res_last   = (div_rsp.quot != '0) || (cnt_q == TIW'(prr_pkg::OUT_LIMIT - 1));

  // Next state and control
  always_comb begin
    state_d          = state_q;
    k_d              = k_q;
    cnt_d            = cnt_q;
    phase_d          = phase_q;
    adv_d            = adv_q;
    wp_d             = wp_q;
    hvalid_d         = hvalid_q;
    adv_dec          = (adv_q != '0) ? adv_q - CW'(1) : '0;
    in_ready         = 1'b0;
    tap_we           = 1'b0;
    hist_we          = 1'b0;
    out_load         = 1'b0;
    // Divider operands
    div_req.dividend = {1'b0, phase_q} + decim_cl;
    div_req.divisor  = interp_cl;
    div_req.start    = 1'b0;
    mac_ctl.clr      = 1'b0;
    mac_ctl.vld      = rd_v_q;
    case (state_q)
      prr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.op == prr_pkg::OP_COEF) begin
            tap_we = 1'b1;
          end else begin
            hist_we              = 1'b1;
            wp_d                 = hist_waddr;
            hvalid_d[hist_waddr] = 1'b1;
            adv_d                = adv_dec;
            if (adv_dec == '0) begin
              state_d     = prr_pkg::ST_MAC;
              k_d         = '0;
              cnt_d       = '0;
              mac_ctl.clr = 1'b1;
            end
          end
        end
      end
      prr_pkg::ST_MAC: begin
        if (k_q == mac_end) begin
          state_d       = prr_pkg::ST_DIV;
          div_req.start = 1'b1;
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      prr_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = prr_pkg::ST_EMIT;
        end
      end
      prr_pkg::ST_EMIT: begin
        if (!out_ch.valid || out_ch.ready) begin
          out_load = 1'b1;
          phase_d  = div_rsp.rem[PHW-1:0];
          adv_d    = div_rsp.quot;
          cnt_d    = cnt_q + TIW'(1);
          if (res_last) begin
            state_d = prr_pkg::ST_IDLE;
          end else begin
            state_d     = prr_pkg::ST_MAC;
            k_d         = '0;
            mac_ctl.clr = 1'b1;
          end
        end
      end
      default: state_d = prr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= prr_pkg::ST_IDLE;
      k_q      <= '0;
      cnt_q    <= '0;
      phase_q  <= '0;
      adv_q    <= CW'(1);
      wp_q     <= '0;
      hvalid_q <= '0;
      rd_v_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      cnt_q    <= cnt_d;
      phase_q  <= phase_d;
      adv_q    <= adv_d;
      wp_q     <= wp_d;
      hvalid_q <= hvalid_d;
      rd_v_q   <= issue;
    end
  end

  // Valid bit follows the history read data
  always_ff @(posedge clk_i) begin
    hv_q <= hvalid_q[hist_raddr];
  end

  // Tap table and history line
  logic [prr_pkg::COEF_W-1:0] tap_rdata;
  logic [prr_pkg::HIST_W-1:0] hist_rdata;

  prr_ram #(
    .WIDTH (prr_pkg::COEF_W),
    .DEPTH (prr_pkg::MAX_PHASES * prr_pkg::MAX_TAPS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i ({in_ch.coef_phase, in_ch.coef_index}),
    .wdata_i (in_ch.coef_value),
    .raddr_i ({phase_q, k_q[TIW-1:0]}),
    .rdata_o (tap_rdata)
  );

  prr_ram #(
    .WIDTH (prr_pkg::HIST_W),
    .DEPTH (NT)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i ({in_ch.sample_i, in_ch.sample_q}),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // Unwritten history entries read as zero
  logic signed [SW-1:0] smp_i, smp_q;
  logic signed [SW-1:0] res_i, res_q;

  assign smp_i = hv_q ? $signed(hist_rdata[2*SW-1:SW]) : '0;
  assign smp_q = hv_q ? $signed(hist_rdata[SW-1:0]) : '0;

  prr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .smp_i_i (smp_i),
    .smp_q_i (smp_q),
    .coef_i  ($signed(tap_rdata)),
    .res_i_o (res_i),
    .res_q_o (res_q)
  );

  prr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register
  logic                 out_vld_q;
  logic signed [SW-1:0] out_i_q, out_q_q;
  logic                 out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_load || (out_vld_q && !out_ch.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_i_q    <= res_i;
      out_q_q    <= res_q;
      out_last_q <= res_last;
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_vld_q;
  assign out_ch.out_i = out_i_q;
  assign out_ch.out_q = out_q_q;
  assign out_ch.last  = out_last_q;

endmodule
